>>> rtl/bbc_pkg.sv
// Shared types and constants for the bracket balance checker.
package bbc_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int CHAR_W          = 8;
    localparam int KIND_W          = 2;
    localparam int ERR_W           = 3;
    localparam int DEPTH_OUT_W     = 6;
    localparam int Q_DEPTH         = 2;

    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_MISMATCH = 3'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd3;
    localparam logic [ERR_W-1:0] ERR_UNCLOSED = 3'd4;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_req;

endpackage

>>> rtl/bbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bbc_front.sv
// Front end: accept characters, classify them into stack requests and register them.
module bbc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [bbc_pkg::CHAR_W-1:0] i_char_in,
    input  logic                       i_last_char,
    output logic                       o_req_valid,
    input  logic                       i_req_ready,
    output bbc_pkg::t_req              o_req
);

    localparam logic [bbc_pkg::CHAR_W-1:0] CH_OPEN_RND  = 8'h28;
    localparam logic [bbc_pkg::CHAR_W-1:0] CH_CLOSE_RND = 8'h29;
    localparam logic [bbc_pkg::CHAR_W-1:0] CH_OPEN_SQR  = 8'h5B;
    localparam logic [bbc_pkg::CHAR_W-1:0] CH_CLOSE_SQR = 8'h5D;
    localparam logic [bbc_pkg::CHAR_W-1:0] CH_OPEN_CRL  = 8'h7B;
    localparam logic [bbc_pkg::CHAR_W-1:0] CH_CLOSE_CRL = 8'h7D;

    localparam logic [bbc_pkg::KIND_W-1:0] KIND_RND = 2'd0;
    localparam logic [bbc_pkg::KIND_W-1:0] KIND_SQR = 2'd1;
    localparam logic [bbc_pkg::KIND_W-1:0] KIND_CRL = 2'd2;

    bbc_pkg::t_req c_req;
    logic          r_valid;
    bbc_pkg::t_req r_req;
    logic          accept;

    always_comb begin
        c_req.last = i_last_char;
        case (i_char_in)
            CH_OPEN_RND: begin
                c_req.op   = bbc_pkg::OP_PUSH;
                c_req.kind = KIND_RND;
            end
            CH_OPEN_SQR: begin
                c_req.op   = bbc_pkg::OP_PUSH;
                c_req.kind = KIND_SQR;
            end
            CH_OPEN_CRL: begin
                c_req.op   = bbc_pkg::OP_PUSH;
                c_req.kind = KIND_CRL;
            end
            CH_CLOSE_RND: begin
                c_req.op   = bbc_pkg::OP_POP;
                c_req.kind = KIND_RND;
            end
            CH_CLOSE_SQR: begin
                c_req.op   = bbc_pkg::OP_POP;
                c_req.kind = KIND_SQR;
            end
            CH_CLOSE_CRL: begin
                c_req.op   = bbc_pkg::OP_POP;
                c_req.kind = KIND_CRL;
            end
            default: begin
                c_req.op   = bbc_pkg::OP_NONE;
                c_req.kind = KIND_RND;
            end
        endcase
    end

    assign o_in_ready = !r_valid || i_req_ready;
    assign accept     = i_in_valid && o_in_ready;

    // drop requests that neither touch the stack nor end a string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= accept && (c_req.op != bbc_pkg::OP_NONE || c_req.last);
        end
        if (accept) begin
            r_req <= c_req;
        end
    end

    assign o_req_valid = r_valid;
    assign o_req       = r_req;

endmodule

>>> rtl/bbc_queue.sv
// Short request queue between the front end and the stack engine.
module bbc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  bbc_pkg::t_req i_wr_req,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output bbc_pkg::t_req o_rd_req
);

    localparam int PTR_W = $clog2(bbc_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(bbc_pkg::Q_DEPTH + 1);

    bbc_pkg::t_req    r_mem [bbc_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_wr_ready = r_cnt != CNT_W'(bbc_pkg::Q_DEPTH);
    assign o_rd_valid = r_cnt != '0;
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;
    assign o_rd_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(bbc_pkg::Q_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_W'(bbc_pkg::Q_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
        if (push) begin
            r_mem[r_wp] <= i_wr_req;
        end
    end

endmodule

>>> rtl/bbc_back.sv
// Stack engine: carry out push and pop requests, track errors, register the verdict.
module bbc_back #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  bbc_pkg::t_req                   i_req,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_balanced,
    output logic [bbc_pkg::ERR_W-1:0]       o_error_kind,
    output logic [bbc_pkg::DEPTH_OUT_W-1:0] o_final_depth
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    logic [CNT_W-1:0]                r_count;
    logic [CNT_W-1:0]                n_count;
    logic [bbc_pkg::KIND_W-1:0]      r_top;
    logic [bbc_pkg::KIND_W-1:0]      n_top;
    logic [bbc_pkg::ERR_W-1:0]       r_err;
    logic [bbc_pkg::ERR_W-1:0]       n_err;
    logic [bbc_pkg::ERR_W-1:0]       fin_err;
    logic [CNT_W-1:0]                rd_cnt;
    logic [bbc_pkg::KIND_W-1:0]      below_top;
    logic                            take;
    logic                            we;
    logic                            r_out_valid;
    logic                            r_balanced;
    logic [bbc_pkg::ERR_W-1:0]       r_error_kind;
    logic [bbc_pkg::DEPTH_OUT_W-1:0] r_final_depth;

    assign take = i_req_valid && (!i_req.last || !r_out_valid || i_out_ready);
    assign o_req_ready = take;

    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        n_err   = r_err;
        we      = 1'b0;
        fin_err = bbc_pkg::ERR_NONE;
        if (take) begin
            if (r_err == bbc_pkg::ERR_NONE) begin
                case (i_req.op)
                    bbc_pkg::OP_PUSH: begin
                        if (r_count == CNT_W'(STACK_DEPTH)) begin
                            n_err = bbc_pkg::ERR_OVERFLOW;
                        end else begin
                            we      = 1'b1;
                            n_count = r_count + CNT_W'(1);
                            n_top   = i_req.kind;
                        end
                    end
                    bbc_pkg::OP_POP: begin
                        if (r_count == '0) begin
                            n_err = bbc_pkg::ERR_EMPTY;
                        end else if (r_top != i_req.kind) begin
                            n_err = bbc_pkg::ERR_MISMATCH;
                        end else begin
                            n_count = r_count - CNT_W'(1);
                            n_top   = below_top;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            fin_err = n_err;
            if (n_err == bbc_pkg::ERR_NONE && n_count != '0) begin
                fin_err = bbc_pkg::ERR_UNCLOSED;
            end
        end
    end

    // prefetch the entry under the next top of stack
    assign rd_cnt = n_count - CNT_W'(2);

    bbc_ram #(
        .WIDTH (bbc_pkg::KIND_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_req.kind),
        .i_raddr (rd_cnt[ADDR_W-1:0]),
        .o_rdata (below_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= bbc_pkg::ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (take && i_req.last) begin
                r_count     <= '0;
                r_err       <= bbc_pkg::ERR_NONE;
                r_out_valid <= 1'b1;
            end else begin
                r_count <= n_count;
                r_err   <= n_err;
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
        r_top <= n_top;
        if (take && i_req.last) begin
            r_balanced    <= fin_err == bbc_pkg::ERR_NONE;
            r_error_kind  <= fin_err;
            r_final_depth <= bbc_pkg::DEPTH_OUT_W'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_balanced    = r_balanced;
    assign o_error_kind  = r_error_kind;
    assign o_final_depth = r_final_depth;

endmodule

>>> rtl/bracket_balance_checker_unit.sv
// Top level of the bracket balance checker.
//
// Input channel: one character byte per request (i_char_in) with i_last_char
// marking the final character of a string; accepted when i_in_valid and
// o_in_ready are both high. Output channel: one verdict per string
// (o_balanced, o_error_kind, o_final_depth), taken when o_out_valid and
// i_out_ready are both high.
// Throughput: one character per cycle while the receiver takes verdicts, set
// by the stack engine, which keeps the top of stack in a register and
// prefetches the entry below it from the stack RAM each cycle, so push and
// pop never wait on a RAM read. The last character of a string passes the
// front register and the queue before its verdict enters the output register.
// Bracket requests pass through a two-entry queue; characters that are not
// brackets and do not end a string are dropped at the front end.
// When the receiver stalls, the verdict holds in the output register and the
// engine keeps working until the next end of string reaches it; the queue
// and front register then fill and o_in_ready falls.
// Reset (synchronous, active low) empties the queue, the stack and the
// sticky error, and drops any pending verdict. No clearing pass is needed.
module bracket_balance_checker_unit #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [bbc_pkg::CHAR_W-1:0]      i_char_in,
    input  logic                            i_last_char,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_balanced,
    output logic [bbc_pkg::ERR_W-1:0]       o_error_kind,
    output logic [bbc_pkg::DEPTH_OUT_W-1:0] o_final_depth
);

    logic          f_valid;
    logic          f_ready;
    bbc_pkg::t_req f_req;
    logic          q_valid;
    logic          q_ready;
    bbc_pkg::t_req q_req;

    bbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_in   (i_char_in),
        .i_last_char (i_last_char),
        .o_req_valid (f_valid),
        .i_req_ready (f_ready),
        .o_req       (f_req)
    );

    bbc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_req   (f_req),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_req   (q_req)
    );

    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (q_valid),
        .o_req_ready   (q_ready),
        .i_req         (q_req),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_balanced    (o_balanced),
        .o_error_kind  (o_error_kind),
        .o_final_depth (o_final_depth)
    );

    a_balanced_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_balanced |->
            o_error_kind == bbc_pkg::ERR_NONE && o_final_depth == '0)
        else $error("balanced verdict carries an error or pending depth");

    a_unbalanced_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_balanced |-> o_error_kind != bbc_pkg::ERR_NONE)
        else $error("unbalanced verdict without an error kind");

    a_error_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_error_kind <= bbc_pkg::ERR_UNCLOSED)
        else $error("error kind out of range");

    a_reset_clears_out: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid)
        else $error("verdict valid right after reset");

endmodule
